>>> sv/nsc_pkg.sv
// Shared types, header table and codes for the NMEA sentence checker.
package nsc_pkg;

  localparam int NUM_HDR = 5;
  localparam int HDR_LEN = 6;
  localparam int POS_W   = 3;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [2:0] TYPE_UNKNOWN = 3'd0;

  // Rows in priority order: GGA, GSA, GSV, RMC, VTG.
  localparam logic [7:0] HDR_TAB [NUM_HDR][HDR_LEN] = '{
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h41},
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h56},
    '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},
    '{8'h24, 8'h47, 8'h50, 8'h56, 8'h54, 8'h47}
  };

  typedef struct packed {
    logic       sentence_valid;
    logic [2:0] sentence_type;
    logic [7:0] computed_checksum;
    logic [7:0] sent_checksum;
    logic       checksum_match;
  } res_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> sv/nmea_sentence_checker.sv
// NMEA 0183 sentence checker: top level with input register.
// The report passes through the input register and the result register on its way to the outputs.
// Throughput: one byte per cycle; input register, scan state and result
// register advance together and halt only while a report is held stalled.
// Reset (rst_n low, synchronous) clears all valids and the scan state.
module nmea_sentence_checker #(
  parameter int MAX_LEN = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_sentence_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_sentence_valid,
  output logic [2:0] out_sentence_type,
  output logic [7:0] out_computed_checksum,
  output logic [7:0] out_sent_checksum,
  output logic       out_checksum_match
);

  logic          en;
  logic          vld_r;
  logic [7:0]    byte_r;
  logic          last_r;
  nsc_pkg::res_t scan_res;
  nsc_pkg::res_t out_res;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      byte_r <= in_sentence_byte;
      last_r <= in_last_byte;
    end
  end

  nsc_scan #(.MAX_LEN(MAX_LEN)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc    (en && vld_r),
    .byte_in (byte_r),
    .last_in (last_r),
    .res     (scan_res)
  );

  nsc_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .load    (vld_r && last_r),
    .res_in  (scan_res),
    .vld     (out_valid),
    .res_out (out_res)
  );

  assign out_sentence_valid    = out_res.sentence_valid;
  assign out_sentence_type     = out_res.sentence_type;
  assign out_computed_checksum = out_res.computed_checksum;
  assign out_sent_checksum     = out_res.sent_checksum;
  assign out_checksum_match    = out_res.checksum_match;

endmodule

>>> sv/nsc_scan.sv
// Per-sentence scan state: checksum, hex field and header matching.
module nsc_scan #(
  parameter int MAX_LEN = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              proc,
  input  logic [7:0]        byte_in,
  input  logic              last_in,
  output nsc_pkg::res_t     res
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {PH_SKIP, PH_TOKEN, PH_DONE} phase_t;

  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         start_r, start_nxt;
  logic                         star_r, star_nxt;
  logic                         ended_r, ended_nxt;
  logic [7:0]                   xor_r, xor_nxt;
  logic [7:0]                   hex_r, hex_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         hstop_r, hstop_nxt;
  logic [nsc_pkg::NUM_HDR-1:0]  cand_r, cand_nxt;
  logic [nsc_pkg::POS_W-1:0]    pos_r, pos_nxt;
  phase_t                       phase_r, phase_nxt;

  nsc_pkg::hex_t               hd;
  logic [nsc_pkg::NUM_HDR-1:0] keep;
  logic                        hdr_take;

  assign hd = nsc_pkg::hex_digit(byte_in);

  always_comb begin
    keep = '0;
    for (int k = 0; k < nsc_pkg::NUM_HDR; k++) begin
      keep[k] = (nsc_pkg::HDR_TAB[k][pos_r] == byte_in);
    end
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    start_nxt = start_r;
    star_nxt  = star_r;
    ended_nxt = ended_r;
    xor_nxt   = xor_r;
    hex_nxt   = hex_r;
    ovf_nxt   = ovf_r;
    hstop_nxt = hstop_r;
    cand_nxt  = cand_r;
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    hdr_take  = 1'b0;
    if (proc && !ended_r && cnt_r < CNT_W'(MAX_LEN)) begin
      cnt_nxt = cnt_r + 1'b1;
      if (byte_in == nsc_pkg::CH_NUL) begin
        ended_nxt = 1'b1;
        if (phase_r == PH_TOKEN) phase_nxt = PH_DONE;
      end else begin
        if (!star_r) begin
          if (byte_in == nsc_pkg::CH_STAR) star_nxt = 1'b1;
          else if (start_r) xor_nxt = xor_r ^ byte_in;
          else if (byte_in == nsc_pkg::CH_DOLLAR) start_nxt = 1'b1;
        end else if (!hstop_r) begin
          if (!hd.is_hex) begin
            hstop_nxt = 1'b1;
          end else begin
            if (hex_r[7:4] != 4'd0) ovf_nxt = 1'b1;
            hex_nxt = {hex_r[3:0], hd.value};
          end
        end
        case (phase_r)
          PH_SKIP: begin
            if (byte_in != nsc_pkg::CH_COMMA) begin
              phase_nxt = PH_TOKEN;
              hdr_take  = 1'b1;
            end
          end
          PH_TOKEN: begin
            if (byte_in == nsc_pkg::CH_COMMA) phase_nxt = PH_DONE;
            else hdr_take = 1'b1;
          end
          default: ;
        endcase
        if (hdr_take) begin
          if (pos_r < nsc_pkg::POS_W'(nsc_pkg::HDR_LEN)) begin
            cand_nxt = cand_r & keep;
            pos_nxt  = pos_r + 1'b1;
          end else begin
            cand_nxt = '0;
          end
        end
      end
    end
  end

  // Result as seen after this beat has been taken in.
  always_comb begin
    logic [2:0] typ;
    logic       match;
    typ = nsc_pkg::TYPE_UNKNOWN;
    res.computed_checksum = (start_nxt && star_nxt) ? xor_nxt : 8'd0;
    res.sent_checksum     = star_nxt ? hex_nxt : 8'd0;
    match = star_nxt && !ovf_nxt && (res.sent_checksum == res.computed_checksum);
    if (phase_nxt != PH_SKIP && pos_nxt == nsc_pkg::POS_W'(nsc_pkg::HDR_LEN)) begin
      for (int k = nsc_pkg::NUM_HDR - 1; k >= 0; k--) begin
        if (cand_nxt[k]) typ = 3'(k + 1);
      end
    end
    res.checksum_match = match;
    res.sentence_valid = match && (typ != nsc_pkg::TYPE_UNKNOWN);
    res.sentence_type  = res.sentence_valid ? typ : nsc_pkg::TYPE_UNKNOWN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (proc && last_in)) begin
      cnt_r   <= '0;
      start_r <= 1'b0;
      star_r  <= 1'b0;
      ended_r <= 1'b0;
      xor_r   <= 8'd0;
      hex_r   <= 8'd0;
      ovf_r   <= 1'b0;
      hstop_r <= 1'b0;
      cand_r  <= '1;
      pos_r   <= '0;
      phase_r <= PH_SKIP;
    end else begin
      cnt_r   <= cnt_nxt;
      start_r <= start_nxt;
      star_r  <= star_nxt;
      ended_r <= ended_nxt;
      xor_r   <= xor_nxt;
      hex_r   <= hex_nxt;
      ovf_r   <= ovf_nxt;
      hstop_r <= hstop_nxt;
      cand_r  <= cand_nxt;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> sv/nsc_out_reg.sv
// Result register holding one finished sentence report until taken.
module nsc_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          load,
  input  nsc_pkg::res_t res_in,
  output logic          vld,
  output nsc_pkg::res_t res_out
);

  logic          vld_r;
  nsc_pkg::res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (en && load) res_r <= res_in;
  end

  assign vld     = vld_r;
  assign res_out = res_r;

endmodule

>>> sv/nsc_checker.sv
// Port-level assertions for the NMEA sentence checker, with bind.
module nsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_sentence_valid,
  input logic [2:0] out_sentence_type,
  input logic [7:0] out_computed_checksum,
  input logic [7:0] out_sent_checksum,
  input logic       out_checksum_match
);

  // A held report stays valid and keeps its checksums and type.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_computed_checksum)
      && $stable(out_sent_checksum) && $stable(out_sentence_type))
    else $error("stalled report changed");

  a_type_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sentence_valid == (out_sentence_type != nsc_pkg::TYPE_UNKNOWN)))
    else $error("type and validity disagree");

  a_valid_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_valid |-> out_checksum_match)
    else $error("valid sentence without checksum match");

  a_match_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_match |-> out_computed_checksum == out_sent_checksum)
    else $error("match flagged on differing checksums");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_sentence_valid    (out_sentence_valid),
  .out_sentence_type     (out_sentence_type),
  .out_computed_checksum (out_computed_checksum),
  .out_sent_checksum     (out_sent_checksum),
  .out_checksum_match    (out_checksum_match)
);
